FILE: hdl/fcr_pkg.sv
// fcr_pkg: shared types and byte codes for the framed command receiver
// used by fcr_decode and framed_command_receiver; no dependencies
package fcr_pkg;

  localparam logic [7:0] BYTE_STX = 8'h02;
  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_CR  = 8'h0D;

  localparam int unsigned CountWidth = 16;

  typedef enum logic [2:0] {
    PH_WAIT_STX = 3'd0,
    PH_LEN_HI   = 3'd1,
    PH_LEN_LO   = 3'd2,
    PH_INSTR    = 3'd3,
    PH_DATA     = 3'd4
  } phase_e;

  typedef struct packed {
    logic write_enable;
    logic line_done;
    logic frame_done;
    logic overflow;
  } flags_t;

endpackage

FILE: hdl/fcr_decode.sv
// fcr_decode: per-byte decision logic, next receiver state and buffer write
// depends on fcr_pkg
module fcr_decode #(
  parameter int unsigned BUF_DEPTH = 1024,
  parameter int unsigned AW        = $clog2(BUF_DEPTH),
  parameter int unsigned PW        = $clog2(BUF_DEPTH + 1)
) (
  input  logic [7:0]                    rx_byte_i,
  input  logic [PW-1:0]                 wpos_i,
  input  logic                          line_mode_i,
  input  fcr_pkg::phase_e               phase_i,
  input  logic [fcr_pkg::CountWidth-1:0] count_i,
  output logic [PW-1:0]                 wpos_o,
  output logic                          line_mode_o,
  output fcr_pkg::phase_e               phase_o,
  output logic [fcr_pkg::CountWidth-1:0] count_o,
  output fcr_pkg::flags_t               flags_o,
  output logic [AW-1:0]                 write_addr_o,
  output logic [7:0]                    write_data_o,
  output logic [PW-1:0]                 line_length_o
);
  import fcr_pkg::*;

  localparam logic [PW-1:0] DepthW = PW'(BUF_DEPTH);

  logic                  full;
  logic                  do_store;
  logic                  rewind;
  logic [CountWidth-1:0] count_dec;

  assign full      = (wpos_i == DepthW);
  assign count_dec = count_i - CountWidth'(1);

  always_comb begin
    do_store      = 1'b0;
    rewind        = 1'b0;
    line_mode_o   = line_mode_i;
    phase_o       = phase_i;
    count_o       = count_i;
    flags_o       = '0;
    line_length_o = '0;

    if (line_mode_i && rx_byte_i == BYTE_CR) begin
      // cr ends the line; frame phase is not looked at
      flags_o.line_done = 1'b1;
      line_length_o     = full ? wpos_i : wpos_i + PW'(1);
      do_store          = 1'b1;
      rewind            = 1'b1;
    end else begin
      if (line_mode_i) begin
        if (rx_byte_i == BYTE_LF) begin
          rewind = 1'b1;
        end else begin
          do_store = 1'b1;
        end
      end
      unique case (phase_i)
        PH_LEN_HI: begin
          do_store = 1'b1;
          count_o  = {rx_byte_i, 8'h00};
          phase_o  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          do_store = 1'b1;
          count_o  = count_i | {8'h00, rx_byte_i};
          phase_o  = PH_INSTR;
        end
        PH_INSTR: begin
          do_store = 1'b1;
          phase_o  = PH_DATA;
        end
        PH_DATA: begin
          do_store = 1'b1;
          count_o  = count_dec;
          if (count_dec == '0) begin
            flags_o.frame_done = 1'b1;
            line_mode_o        = 1'b1;
            phase_o            = PH_WAIT_STX;
          end
        end
        default: begin
          if (rx_byte_i == BYTE_STX) begin
            phase_o     = PH_LEN_HI;
            line_mode_o = 1'b0;
          end else begin
            phase_o = PH_WAIT_STX;
          end
        end
      endcase
    end

    flags_o.write_enable = do_store && !full;
    flags_o.overflow     = do_store && full;
  end

  assign write_addr_o = flags_o.write_enable ? wpos_i[AW-1:0] : '0;
  assign write_data_o = flags_o.write_enable ? rx_byte_i : 8'h00;
  assign wpos_o       = rewind ? '0 :
                        (flags_o.write_enable ? wpos_i + PW'(1) : wpos_i);

endmodule

FILE: hdl/framed_command_receiver.sv
// framed_command_receiver: top level, input stage, receiver state and result register
// depends on fcr_pkg and fcr_decode
//
// Takes one serial byte per item and returns one result item per byte: a buffer
// write (enable, address, data) plus line_done, line_length, overflow and, on
// tlast, frame_done. Sustains one item per clock while the output is not
// back-pressured. The byte lands in the input stage register when accepted; the
// result register then loads from it, with the receiver state update, once the
// output stage is free. Both registers advance under back-pressure only when the
// next stage is free.
module framed_command_receiver #(
  parameter int unsigned BUF_DEPTH = 1024,
  parameter int unsigned AW        = $clog2(BUF_DEPTH),
  parameter int unsigned PW        = $clog2(BUF_DEPTH + 1),
  parameter int unsigned OUT_W     = ((11 + AW + PW + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,  // rx_byte
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // write_enable, write_addr, write_data, line_done, line_length, overflow, zero pad
  output logic [OUT_W-1:0] m_axis_tdata,
  output logic             m_axis_tlast   // frame_done
);
  import fcr_pkg::*;

  localparam int unsigned PackW = 11 + AW + PW;

  logic                  in_valid_q;
  logic [7:0]            in_byte_q;
  logic                  out_valid_q;
  logic [OUT_W-1:0]      out_data_q;
  logic                  out_last_q;
  logic [PW-1:0]         wpos_q, wpos_d;
  logic                  line_mode_q, line_mode_d;
  phase_e                phase_q, phase_d;
  logic [CountWidth-1:0] count_q, count_d;

  flags_t                flags;
  logic [AW-1:0]         write_addr;
  logic [7:0]            write_data;
  logic [PW-1:0]         line_length;
  logic                  advance;
  logic [PackW-1:0]      packed_result;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  fcr_decode #(
    .BUF_DEPTH(BUF_DEPTH),
    .AW       (AW),
    .PW       (PW)
  ) u_decode (
    .rx_byte_i    (in_byte_q),
    .wpos_i       (wpos_q),
    .line_mode_i  (line_mode_q),
    .phase_i      (phase_q),
    .count_i      (count_q),
    .wpos_o       (wpos_d),
    .line_mode_o  (line_mode_d),
    .phase_o      (phase_d),
    .count_o      (count_d),
    .flags_o      (flags),
    .write_addr_o (write_addr),
    .write_data_o (write_data),
    .line_length_o(line_length)
  );

  assign packed_result = {flags.overflow, line_length, flags.line_done,
                          write_data, write_addr, flags.write_enable};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      wpos_q      <= '0;
      line_mode_q <= 1'b1;
      phase_q     <= PH_WAIT_STX;
      count_q     <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        wpos_q      <= wpos_d;
        line_mode_q <= line_mode_d;
        phase_q     <= phase_d;
        count_q     <= count_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
    if (advance) begin
      out_data_q <= OUT_W'(packed_result);
      out_last_q <= flags.frame_done;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // line mode and the wait-for-stx phase always go together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_mode_q == (phase_q == PH_WAIT_STX))
    else $error("line mode and frame phase disagree");

  // a dropped store never also writes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> !(out_data_q[0] && out_data_q[PackW-1]))
    else $error("overflow together with write enable");

  // line length only on a line end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !flags.line_done |=> out_data_q[PackW-2 -: PW] == '0)
    else $error("line length without line end");

  // a line end and a frame end never share an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |-> !(flags.line_done && flags.frame_done))
    else $error("line and frame end together");

  // the write position never passes the buffer depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wpos_q <= PW'(BUF_DEPTH))
    else $error("write position beyond buffer");

endmodule
